>>> rtl/core/lavm_pkg.sv
package lavm_pkg;

    localparam int FIELD_BITS   = 32;
    localparam int DIFF_BITS    = 33;
    localparam int WIDE_BITS    = 64;
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_Z = 2'd2;

    localparam logic [3:0] CROSS_STEPS = 4'd6;
    localparam logic [3:0] DOT_STEPS   = 4'd9;

    typedef logic signed [FIELD_BITS-1:0] word_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;

    // one accepted camera: eye, eye - target and the up vector, all sign-extended
    typedef struct packed {
        word_t [2:0] eye;
        diff_t [2:0] d;
        word_t [2:0] up;
    } job_t;

    typedef struct packed {
        logic        start;
        wide_t [2:0] v;
    } norm_req_t;

    typedef struct packed {
        logic        done;
        word_t [2:0] a;
    } norm_rsp_t;

    // one multiply step: operand indexes, accumulate control, destination lane
    typedef struct packed {
        logic [1:0] ia;
        logic [1:0] ib;
        logic       first;
        logic       last;
        logic [1:0] dst;
    } mstep_t;

    // r0 = a1 b2 - a2 b1, r1 = a2 b0 - a0 b2, r2 = a0 b1 - a1 b0
    function automatic mstep_t cross_step(input logic [3:0] p);
        mstep_t s;
        s = '0;
        case (p)
            4'd0: s = '{ia: 2'd1, ib: 2'd2, first: 1'b1, last: 1'b0, dst: 2'd0};
            4'd1: s = '{ia: 2'd2, ib: 2'd1, first: 1'b0, last: 1'b1, dst: 2'd0};
            4'd2: s = '{ia: 2'd2, ib: 2'd0, first: 1'b1, last: 1'b0, dst: 2'd1};
            4'd3: s = '{ia: 2'd0, ib: 2'd2, first: 1'b0, last: 1'b1, dst: 2'd1};
            4'd4: s = '{ia: 2'd0, ib: 2'd1, first: 1'b1, last: 1'b0, dst: 2'd2};
            4'd5: s = '{ia: 2'd1, ib: 2'd0, first: 1'b0, last: 1'b1, dst: 2'd2};
            default: s = '0;
        endcase
        return s;
    endfunction

    // three dot products, axis in dst, component in ia/ib
    function automatic mstep_t dot_step(input logic [3:0] p);
        mstep_t s;
        s = '0;
        case (p)
            4'd0: s = '{ia: 2'd0, ib: 2'd0, first: 1'b1, last: 1'b0, dst: 2'd0};
            4'd1: s = '{ia: 2'd1, ib: 2'd1, first: 1'b0, last: 1'b0, dst: 2'd0};
            4'd2: s = '{ia: 2'd2, ib: 2'd2, first: 1'b0, last: 1'b1, dst: 2'd0};
            4'd3: s = '{ia: 2'd0, ib: 2'd0, first: 1'b1, last: 1'b0, dst: 2'd1};
            4'd4: s = '{ia: 2'd1, ib: 2'd1, first: 1'b0, last: 1'b0, dst: 2'd1};
            4'd5: s = '{ia: 2'd2, ib: 2'd2, first: 1'b0, last: 1'b1, dst: 2'd1};
            4'd6: s = '{ia: 2'd0, ib: 2'd0, first: 1'b1, last: 1'b0, dst: 2'd2};
            4'd7: s = '{ia: 2'd1, ib: 2'd1, first: 1'b0, last: 1'b0, dst: 2'd2};
            4'd8: s = '{ia: 2'd2, ib: 2'd2, first: 1'b0, last: 1'b1, dst: 2'd2};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/core/lavm_channels.sv
interface lavm_cfg_if
    import lavm_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    word_t                   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface lavm_item_if
    import lavm_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t eye_x;
    word_t eye_y;
    word_t eye_z;
    word_t target_x;
    word_t target_y;
    word_t target_z;

    modport source (output valid, output eye_x, output eye_y, output eye_z,
                    output target_x, output target_y, output target_z, input ready);
    modport sink (input valid, input eye_x, input eye_y, input eye_z,
                  input target_x, input target_y, input target_z, output ready);
endinterface

interface lavm_result_if
    import lavm_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] column_index;
    word_t      elem_row0;
    word_t      elem_row1;
    word_t      elem_row2;
    word_t      elem_row3;
    logic       last_column;

    modport source (output valid, output column_index, output elem_row0, output elem_row1,
                    output elem_row2, output elem_row3, output last_column, input ready);
    modport sink (input valid, input column_index, input elem_row0, input elem_row1,
                  input elem_row2, input elem_row3, input last_column, output ready);
endinterface

>>> rtl/core/lavm_fifo.sv
module lavm_fifo
    import lavm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);
    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

>>> rtl/core/lavm_front.sv
module lavm_front
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int W_EFF     = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    lavm_cfg_if.sink    cfg,
    lavm_item_if.sink   item,
    output logic        push_valid,
    input  logic        push_ready,
    output job_t        push_data
);
    word_t up_x_reg;
    word_t up_y_reg;
    word_t up_z_reg;
    word_t eye_s [3];
    word_t tgt_s [3];

    // sign-extend from the working word width
    function automatic word_t sx(input word_t v);
        logic signed [W_EFF-1:0] t;
        t = v[W_EFF-1:0];
        return word_t'(t);
    endfunction

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_x_reg <= '0;
            up_y_reg <= word_t'(1) << FRAC_BITS;
            up_z_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_UP_X: up_x_reg <= cfg.data;
                REG_UP_Y: up_y_reg <= cfg.data;
                REG_UP_Z: up_z_reg <= cfg.data;
                default:  ;
            endcase
        end
    end

    assign item.ready = push_ready;
    assign push_valid = item.valid;

    always_comb
    begin
        eye_s[0] = sx(item.eye_x);
        eye_s[1] = sx(item.eye_y);
        eye_s[2] = sx(item.eye_z);
        tgt_s[0] = sx(item.target_x);
        tgt_s[1] = sx(item.target_y);
        tgt_s[2] = sx(item.target_z);
        for (int i = 0; i < 3; i++)
        begin
            push_data.eye[i] = eye_s[i];
            push_data.d[i]   = diff_t'(eye_s[i]) - diff_t'(tgt_s[i]);
        end
        push_data.up[0] = sx(up_x_reg);
        push_data.up[1] = sx(up_y_reg);
        push_data.up[2] = sx(up_z_reg);
    end
endmodule

>>> rtl/core/lavm_norm.sv
module lavm_norm
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  norm_req_t req,
    output norm_rsp_t rsp
);
    localparam int QB = FRAC_BITS + 2;

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_MAX   = 3'd1;
    localparam logic [2:0] N_SCALE = 3'd2;
    localparam logic [2:0] N_SQ    = 3'd3;
    localparam logic [2:0] N_ROOT  = 3'd4;
    localparam logic [2:0] N_DIVLD = 3'd5;
    localparam logic [2:0] N_DIV   = 3'd6;
    localparam logic [2:0] N_DONE  = 3'd7;

    localparam logic [63:0] MAG_TOP    = 64'd1 << 30;
    localparam logic [63:0] MAG_LOW    = 64'd1 << 29;
    localparam logic [63:0] MAG_FAR_HI = 64'd1 << 38;
    localparam logic [63:0] MAG_FAR_LO = 64'd1 << 21;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [63:0] mg_reg [3];
    logic [63:0] mg_next [3];
    logic [2:0]  neg_reg, neg_next;
    logic [63:0] m_reg, m_next;
    logic [59:0] prod_reg, prod_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] r_reg, r_next;
    logic [31:0] rem_reg [3];
    logic [31:0] rem_next [3];
    logic [31:0] low_reg [3];
    logic [31:0] low_next [3];
    logic [31:0] q_reg [3];
    logic [31:0] q_next [3];
    word_t       a_reg [3];
    word_t       a_next [3];

    logic [63:0] mag_in [3];
    logic [63:0] max01, max_all;
    logic [29:0] sq_op;
    logic [63:0] root_bit, root_try;
    logic [31:0] len;
    logic [63:0] num [3];
    logic [63:0] low_sh [3];
    logic [32:0] div_try [3];

    always_comb
    begin
        len = r_reg[31:0];
        for (int i = 0; i < 3; i++)
        begin
            mag_in[i]  = req.v[i][63] ? (~req.v[i] + 64'd1) : req.v[i];
            num[i]     = (mg_reg[i] << FRAC_BITS) + {33'd0, len[31:1]};
            low_sh[i]  = num[i] << (32 - QB);
            div_try[i] = {rem_reg[i], low_reg[i][31]};
        end
        max01    = (mg_reg[0] > mg_reg[1]) ? mg_reg[0] : mg_reg[1];
        max_all  = (max01 > mg_reg[2]) ? max01 : mg_reg[2];
        sq_op    = (cnt_reg < 6'd3) ? mg_reg[cnt_reg[1:0]][29:0] : 30'd0;
        root_bit = 64'd1 << {cnt_reg[4:0], 1'b0};
        root_try = r_reg + root_bit;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        m_next     = m_reg;
        prod_next  = prod_reg;
        x_next     = x_reg;
        r_next     = r_reg;
        for (int i = 0; i < 3; i++)
        begin
            mg_next[i]  = mg_reg[i];
            rem_next[i] = rem_reg[i];
            low_next[i] = low_reg[i];
            q_next[i]   = q_reg[i];
            a_next[i]   = a_reg[i];
        end

        case (state_reg)
            N_IDLE:
            begin
                if (req.start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mg_next[i]  = mag_in[i];
                        neg_next[i] = req.v[i][63];
                    end
                    state_next = N_MAX;
                end
            end
            N_MAX:
            begin
                if (max_all == 64'd0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        a_next[i] = '0;
                    end
                    done_next  = 1'b1;
                    state_next = N_IDLE;
                end
                else
                begin
                    m_next     = max_all;
                    state_next = N_SCALE;
                end
            end
            N_SCALE:
            begin
                // bring the largest magnitude into [2^29, 2^30)
                if (m_reg >= MAG_FAR_HI)
                begin
                    m_next = m_reg >> 8;
                    for (int i = 0; i < 3; i++) mg_next[i] = mg_reg[i] >> 8;
                end
                else if (m_reg >= MAG_TOP)
                begin
                    m_next = m_reg >> 1;
                    for (int i = 0; i < 3; i++) mg_next[i] = mg_reg[i] >> 1;
                end
                else if (m_reg < MAG_FAR_LO)
                begin
                    m_next = m_reg << 8;
                    for (int i = 0; i < 3; i++) mg_next[i] = mg_reg[i] << 8;
                end
                else if (m_reg < MAG_LOW)
                begin
                    m_next = m_reg << 1;
                    for (int i = 0; i < 3; i++) mg_next[i] = mg_reg[i] << 1;
                end
                else
                begin
                    x_next     = '0;
                    cnt_next   = 6'd0;
                    state_next = N_SQ;
                end
            end
            N_SQ:
            begin
                prod_next = sq_op * sq_op;
                if (cnt_reg != 6'd0)
                begin
                    x_next = x_reg + {4'd0, prod_reg};
                end
                if (cnt_reg == 6'd3)
                begin
                    r_next     = '0;
                    cnt_next   = 6'd31;
                    state_next = N_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            N_ROOT:
            begin
                if (x_reg >= root_try)
                begin
                    x_next = x_reg - root_try;
                    r_next = (r_reg >> 1) + root_bit;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                if (cnt_reg == 6'd0)
                begin
                    state_next = N_DIVLD;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            N_DIVLD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_next[i] = 32'(num[i] >> QB);
                    low_next[i] = low_sh[i][31:0];
                    q_next[i]   = '0;
                end
                cnt_next   = 6'(QB - 1);
                state_next = N_DIV;
            end
            N_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (div_try[i] >= {1'b0, len})
                    begin
                        rem_next[i] = 32'(div_try[i] - {1'b0, len});
                        q_next[i]   = {q_reg[i][30:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[i] = div_try[i][31:0];
                        q_next[i]   = {q_reg[i][30:0], 1'b0};
                    end
                    low_next[i] = low_reg[i] << 1;
                end
                if (cnt_reg == 6'd0)
                begin
                    state_next = N_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            N_DONE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    a_next[i] = word_t'(neg_reg[i] ? (32'd0 - q_reg[i]) : q_reg[i]);
                end
                done_next  = 1'b1;
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        m_reg    <= m_next;
        prod_reg <= prod_next;
        x_reg    <= x_next;
        r_reg    <= r_next;
        for (int i = 0; i < 3; i++)
        begin
            mg_reg[i]  <= mg_next[i];
            rem_reg[i] <= rem_next[i];
            low_reg[i] <= low_next[i];
            q_reg[i]   <= q_next[i];
            a_reg[i]   <= a_next[i];
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        for (int i = 0; i < 3; i++)
        begin
            rsp.a[i] = a_reg[i];
        end
    end
endmodule

>>> rtl/core/lavm_back.sv
module lavm_back
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int W_EFF     = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  job_t          pop_data,
    lavm_result_if.source result
);
    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_NF   = 4'd1;
    localparam logic [3:0] B_X1   = 4'd2;
    localparam logic [3:0] B_NS   = 4'd3;
    localparam logic [3:0] B_X2   = 4'd4;
    localparam logic [3:0] B_NU   = 4'd5;
    localparam logic [3:0] B_DOT  = 4'd6;
    localparam logic [3:0] B_TR   = 4'd7;
    localparam logic [3:0] B_HAND = 4'd8;

    function automatic word_t sat_w(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (W_EFF - 1)) - wide_t'(1);
        lo = -hi - wide_t'(1);
        if (v > hi)
        begin
            return word_t'(hi);
        end
        if (v < lo)
        begin
            return word_t'(lo);
        end
        return word_t'(v);
    endfunction

    localparam word_t ONE_SAT = sat_w(wide_t'(1) <<< FRAC_BITS);

    logic [3:0] state_reg, state_next;
    logic [3:0] t_reg, t_next;
    logic       start_reg, start_next;
    logic       out_busy_reg, out_busy_next;
    logic [1:0] col_reg, col_next;

    word_t eye_reg [3];
    word_t eye_next [3];
    word_t up_reg [3];
    word_t up_next [3];
    diff_t d_reg [3];
    diff_t d_next [3];
    word_t f_reg [3];
    word_t f_next [3];
    word_t s_reg [3];
    word_t s_next [3];
    word_t u_reg [3];
    word_t u_next [3];
    wide_t vec_reg [3];
    wide_t vec_next [3];
    wide_t dsum_reg [3];
    wide_t dsum_next [3];
    word_t tr_reg [3];
    word_t tr_next [3];
    word_t os_reg [3];
    word_t os_next [3];
    word_t ou_reg [3];
    word_t ou_next [3];
    word_t of_reg [3];
    word_t of_next [3];
    word_t otr_reg [3];
    word_t otr_next [3];
    wide_t acc_reg, acc_next;
    wide_t prod_reg, prod_next;

    norm_req_t   norm_req;
    norm_rsp_t   norm_rsp;
    logic        is_dot;
    logic        in_mul;
    mstep_t      cur;
    mstep_t      prv;
    logic [3:0]  n_steps;
    word_t       mul_a, mul_b;
    wide_t       sum_val;
    wide_t       tr_d;
    logic [63:0] tr_mag;
    logic [63:0] tr_rnd;
    wide_t       tr_val;

    lavm_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (norm_req),
        .rsp   (norm_rsp)
    );

    always_comb
    begin
        norm_req.start = start_reg;
        for (int i = 0; i < 3; i++)
        begin
            norm_req.v[i] = (state_reg == B_NF) ? wide_t'(d_reg[i]) : vec_reg[i];
        end
    end

    assign pop_ready = (state_reg == B_IDLE);

    always_comb
    begin
        is_dot  = (state_reg == B_DOT);
        in_mul  = (state_reg == B_X1) || (state_reg == B_X2) || (state_reg == B_DOT);
        cur     = is_dot ? dot_step(t_reg) : cross_step(t_reg);
        prv     = is_dot ? dot_step(t_reg - 4'd1) : cross_step(t_reg - 4'd1);
        n_steps = is_dot ? DOT_STEPS : CROSS_STEPS;

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            B_X1:
            begin
                mul_a = up_reg[cur.ia];
                mul_b = f_reg[cur.ib];
            end
            B_X2:
            begin
                mul_a = f_reg[cur.ia];
                mul_b = s_reg[cur.ib];
            end
            B_DOT:
            begin
                case (cur.dst)
                    2'd0:    mul_a = s_reg[cur.ia];
                    2'd1:    mul_a = u_reg[cur.ia];
                    default: mul_a = f_reg[cur.ia];
                endcase
                mul_b = eye_reg[cur.ib];
            end
            default: ;
        endcase

        sum_val = prv.first ? prod_reg : (is_dot ? acc_reg + prod_reg : acc_reg - prod_reg);

        // -(axis . eye): round half away from zero, then saturate
        tr_d   = (t_reg < 4'd3) ? dsum_reg[t_reg[1:0]] : '0;
        tr_mag = tr_d[63] ? (~tr_d + 64'd1) : tr_d;
        tr_rnd = (tr_mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        tr_val = tr_d[63] ? wide_t'(tr_rnd) : -wide_t'(tr_rnd);
    end

    always_comb
    begin
        state_next    = state_reg;
        t_next        = t_reg;
        start_next    = 1'b0;
        out_busy_next = out_busy_reg;
        col_next      = col_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        for (int i = 0; i < 3; i++)
        begin
            eye_next[i]  = eye_reg[i];
            up_next[i]   = up_reg[i];
            d_next[i]    = d_reg[i];
            f_next[i]    = f_reg[i];
            s_next[i]    = s_reg[i];
            u_next[i]    = u_reg[i];
            vec_next[i]  = vec_reg[i];
            dsum_next[i] = dsum_reg[i];
            tr_next[i]   = tr_reg[i];
            os_next[i]   = os_reg[i];
            ou_next[i]   = ou_reg[i];
            of_next[i]   = of_reg[i];
            otr_next[i]  = otr_reg[i];
        end

        // output drain, one column per transfer
        if (out_busy_reg && result.ready)
        begin
            if (col_reg == 2'd3)
            begin
                out_busy_next = 1'b0;
            end
            else
            begin
                col_next = col_reg + 2'd1;
            end
        end

        if (in_mul)
        begin
            prod_next = mul_a * mul_b;
            if (t_reg != 4'd0)
            begin
                acc_next = sum_val;
                if (prv.last)
                begin
                    if (is_dot)
                    begin
                        dsum_next[prv.dst] = sum_val;
                    end
                    else
                    begin
                        vec_next[prv.dst] = sum_val;
                    end
                end
            end
            if (t_reg == n_steps)
            begin
                t_next = 4'd0;
            end
            else
            begin
                t_next = t_reg + 4'd1;
            end
        end

        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        eye_next[i] = pop_data.eye[i];
                        up_next[i]  = pop_data.up[i];
                        d_next[i]   = pop_data.d[i];
                    end
                    start_next = 1'b1;
                    state_next = B_NF;
                end
            end
            B_NF:
            begin
                if (norm_rsp.done)
                begin
                    for (int i = 0; i < 3; i++) f_next[i] = norm_rsp.a[i];
                    t_next     = 4'd0;
                    state_next = B_X1;
                end
            end
            B_X1:
            begin
                if (t_reg == n_steps)
                begin
                    start_next = 1'b1;
                    state_next = B_NS;
                end
            end
            B_NS:
            begin
                if (norm_rsp.done)
                begin
                    for (int i = 0; i < 3; i++) s_next[i] = norm_rsp.a[i];
                    t_next     = 4'd0;
                    state_next = B_X2;
                end
            end
            B_X2:
            begin
                if (t_reg == n_steps)
                begin
                    start_next = 1'b1;
                    state_next = B_NU;
                end
            end
            B_NU:
            begin
                if (norm_rsp.done)
                begin
                    for (int i = 0; i < 3; i++) u_next[i] = norm_rsp.a[i];
                    t_next     = 4'd0;
                    state_next = B_DOT;
                end
            end
            B_DOT:
            begin
                if (t_reg == n_steps)
                begin
                    state_next = B_TR;
                end
            end
            B_TR:
            begin
                tr_next[t_reg[1:0]] = sat_w(tr_val);
                if (t_reg == 4'd2)
                begin
                    t_next     = 4'd0;
                    state_next = B_HAND;
                end
                else
                begin
                    t_next = t_reg + 4'd1;
                end
            end
            B_HAND:
            begin
                if (!out_busy_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        os_next[i]  = sat_w(wide_t'(s_reg[i]));
                        ou_next[i]  = sat_w(wide_t'(u_reg[i]));
                        of_next[i]  = sat_w(wide_t'(f_reg[i]));
                        otr_next[i] = tr_reg[i];
                    end
                    out_busy_next = 1'b1;
                    col_next      = 2'd0;
                    state_next    = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            t_reg        <= '0;
            start_reg    <= 1'b0;
            out_busy_reg <= 1'b0;
            col_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            t_reg        <= t_next;
            start_reg    <= start_next;
            out_busy_reg <= out_busy_next;
            col_reg      <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        for (int i = 0; i < 3; i++)
        begin
            eye_reg[i]  <= eye_next[i];
            up_reg[i]   <= up_next[i];
            d_reg[i]    <= d_next[i];
            f_reg[i]    <= f_next[i];
            s_reg[i]    <= s_next[i];
            u_reg[i]    <= u_next[i];
            vec_reg[i]  <= vec_next[i];
            dsum_reg[i] <= dsum_next[i];
            tr_reg[i]   <= tr_next[i];
            os_reg[i]   <= os_next[i];
            ou_reg[i]   <= ou_next[i];
            of_reg[i]   <= of_next[i];
            otr_reg[i]  <= otr_next[i];
        end
    end

    always_comb
    begin
        result.valid        = out_busy_reg;
        result.column_index = col_reg;
        result.last_column  = (col_reg == 2'd3);
        case (col_reg)
            2'd0:
            begin
                result.elem_row0 = os_reg[0];
                result.elem_row1 = ou_reg[0];
                result.elem_row2 = of_reg[0];
                result.elem_row3 = '0;
            end
            2'd1:
            begin
                result.elem_row0 = os_reg[1];
                result.elem_row1 = ou_reg[1];
                result.elem_row2 = of_reg[1];
                result.elem_row3 = '0;
            end
            2'd2:
            begin
                result.elem_row0 = os_reg[2];
                result.elem_row1 = ou_reg[2];
                result.elem_row2 = of_reg[2];
                result.elem_row3 = '0;
            end
            default:
            begin
                result.elem_row0 = otr_reg[0];
                result.elem_row1 = otr_reg[1];
                result.elem_row2 = otr_reg[2];
                result.elem_row3 = ONE_SAT;
            end
        endcase
    end
endmodule

>>> rtl/core/look_at_view_matrix.sv
// Channel   Dir  Handshake      Payload
// cfg       in   valid/ready    index (up_x, up_y, up_z), data
// item      in   valid/ready    eye_x/y/z, target_x/y/z
// result    out  valid/ready    column_index, elem_row0..3, last_column
//
// Work per item is set by three passes through the normalizer (scaling
//   steps, then a 32-step square root, then a FRAC_BITS+2 step divide,
//   3 lanes). A zero axis skips its pass, so eye on target skips all three.
// Items are taken while the back end works; a 2-entry queue holds them.
// Reset: asynchronous, clears all control state; no clearing pass.
// Stalls: result holds its column until taken; the back end finishes the next
//   matrix and waits for the output register to empty.
module look_at_view_matrix
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic          clk,
    input  logic          rst_n,
    lavm_cfg_if.sink      cfg,
    lavm_item_if.sink     item,
    lavm_result_if.source result
);
    // working width: fields are 32 bits, narrower words are sign-extended
    localparam int W_EFF = (WORD_BITS > FIELD_BITS) ? FIELD_BITS : WORD_BITS;

    logic push_valid;
    logic push_ready;
    job_t push_data;
    logic pop_valid;
    logic pop_ready;
    job_t pop_data;

    // front: config registers, sign extension, eye - target
    lavm_front #(
        .FRAC_BITS (FRAC_BITS),
        .W_EFF     (W_EFF)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue between front and back
    lavm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: normalize, cross, dot, translate, then four column transfers
    lavm_back #(
        .FRAC_BITS (FRAC_BITS),
        .W_EFF     (W_EFF)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );
endmodule
